[hdl/lsm_pkg.sv]
`default_nettype none

package lsm_pkg;

  // widths fixed by the item format
  localparam int unsigned IdW      = 32;
  localparam int unsigned SlotNumW = 4;

  // default number of slots
  localparam int unsigned SlotsDef = 8;

  // an empty slot holds all ones, which no accepted identifier can equal
  localparam logic [IdW-1:0] EmptyTag = '1;

  // control handed from the sequencer to every cell of the recency chain
  typedef struct packed {
    logic cmp;     // compare the stored tag against the pending identifier
    logic commit;  // apply the recency update this cycle
    logic miss;    // no cell matched: the oldest cell is evicted
  } cell_ctrl_t;

endpackage

`default_nettype wire

[hdl/lsm_cell.sv]
`default_nettype none

// one position of the recency chain; position 0 is the oldest
module lsm_cell #(
  parameter int unsigned SlotW = 3,
  parameter int unsigned Index = 0
) (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire  lsm_pkg::cell_ctrl_t   ctrl_i,
  input  wire  [lsm_pkg::IdW-1:0]     id_i,
  input  wire                         seen_i,
  input  wire  [lsm_pkg::IdW-1:0]     nb_tag_i,
  input  wire  [SlotW-1:0]            nb_slot_i,
  output logic [lsm_pkg::IdW-1:0]     tag_o,
  output logic [SlotW-1:0]            slot_o,
  output logic                        match_o,
  output logic                        seen_o
);

  logic [lsm_pkg::IdW-1:0] tag_q, tag_d;
  logic [SlotW-1:0]        slot_q, slot_d;
  logic                    match_q, match_d;
  logic                    shift;

  // this cell and every newer one move down once the hit position is reached
  assign seen_o = seen_i | match_q;
  assign shift  = ctrl_i.commit & (ctrl_i.miss | seen_o);

  always_comb begin
    tag_d   = tag_q;
    slot_d  = slot_q;
    match_d = match_q;
    if (ctrl_i.cmp) begin
      match_d = (tag_q == id_i);
    end
    if (shift) begin
      tag_d  = nb_tag_i;
      slot_d = nb_slot_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q   <= lsm_pkg::EmptyTag;
      slot_q  <= SlotW'(Index);
      match_q <= 1'b0;
    end else begin
      tag_q   <= tag_d;
      slot_q  <= slot_d;
      match_q <= match_d;
    end
  end

  assign tag_o   = tag_q;
  assign slot_o  = slot_q;
  assign match_o = match_q;

endmodule

`default_nettype wire

[hdl/lru_id_to_slot_mapper_top.sv]
`default_nettype none

// channel | direction | handshake              | payload
// --------+-----------+------------------------+------------------------------------------
// in      | input     | in_valid_i / in_stall_o | identifier_i (32, signed)
// out     | output    | out_valid_o / out_stall_i | accepted_o, slot_number_o, was_present_o
//
// each item passes a compare state, which checks all cells against the identifier,
// then an update state, which shifts the recency chain and loads the result register
// a new item is taken in the update state, as the last item completes its update
// reset empties all slots and orders them 0 (oldest) to SLOTS-1 (newest)
// while a result waits under out_stall_i the update state holds and the input stalls in it
module lru_id_to_slot_mapper_top #(
  parameter int unsigned SLOTS = lsm_pkg::SlotsDef
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              in_valid_i,
  output logic                             in_stall_o,
  input  wire  signed [lsm_pkg::IdW-1:0]   identifier_i,
  output logic                             out_valid_o,
  input  wire                              out_stall_i,
  output logic                             accepted_o,
  output logic [lsm_pkg::SlotNumW-1:0]     slot_number_o,
  output logic                             was_present_o
);

  localparam int unsigned SlotW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  // sequencer states
  localparam logic [1:0] StIdle   = 2'd0;
  localparam logic [1:0] StCmp    = 2'd1;
  localparam logic [1:0] StCommit = 2'd2;

  logic [1:0] state_q, state_d;

  logic [lsm_pkg::IdW-1:0] id_q;

  logic                          out_valid_q;
  logic                          accepted_q;
  logic [lsm_pkg::SlotNumW-1:0]  slot_number_q;
  logic                          was_present_q;

  logic in_xfer;
  logic out_free;
  logic commit;
  logic id_null;

  lsm_pkg::cell_ctrl_t ctrl;

  // chain wiring: index SLOTS on the neighbor side is the incoming entry
  logic [lsm_pkg::IdW-1:0] tag_w  [SLOTS];
  logic [SlotW-1:0]        slot_w [SLOTS];
  logic [SLOTS-1:0]        match_w;
  logic [SLOTS:0]          seen_w;

  logic             hit;
  logic [SlotW-1:0] sel_slot;
  logic [SlotW:0]   slot_plus_one;

  // output register frees up in the same cycle its transfer completes
  assign out_free = !out_valid_q || !out_stall_i;
  assign commit   = (state_q == StCommit) && out_free;
  assign id_null  = id_q[lsm_pkg::IdW-1];

  assign in_stall_o = !((state_q == StIdle) || commit);
  assign in_xfer    = in_valid_i && !in_stall_o;

  // the sign bit marks a null item, which never hits
  assign hit = (|match_w) && !id_null;

  // slot of the matching cell, or of the oldest cell on a miss
  always_comb begin
    sel_slot = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (match_w[i]) begin
        sel_slot = sel_slot | slot_w[i];
      end
    end
    if (!hit) begin
      sel_slot = slot_w[0];
    end
  end

  assign slot_plus_one = {1'b0, sel_slot} + (SlotW+1)'(1);

  assign ctrl.cmp    = (state_q == StCmp);
  assign ctrl.commit = commit && !id_null;
  assign ctrl.miss   = !hit;

  assign seen_w[0] = 1'b0;

  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    logic [lsm_pkg::IdW-1:0] nb_tag;
    logic [SlotW-1:0]        nb_slot;

    // the newest cell takes the identifier and the slot it now owns
    if (g == SLOTS-1) begin : g_newest
      assign nb_tag  = id_q;
      assign nb_slot = sel_slot;
    end else begin : g_inner
      assign nb_tag  = tag_w[g+1];
      assign nb_slot = slot_w[g+1];
    end

    lsm_cell #(
      .SlotW (SlotW),
      .Index (g)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (ctrl),
      .id_i      (id_q),
      .seen_i    (seen_w[g]),
      .nb_tag_i  (nb_tag),
      .nb_slot_i (nb_slot),
      .tag_o     (tag_w[g]),
      .slot_o    (slot_w[g]),
      .match_o   (match_w[g]),
      .seen_o    (seen_w[g+1])
    );
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (in_xfer) begin
          state_d = StCmp;
        end
      end
      StCmp: begin
        state_d = StCommit;
      end
      StCommit: begin
        if (commit) begin
          state_d = in_xfer ? StCmp : StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (commit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      id_q <= identifier_i;
    end
    if (commit) begin
      accepted_q    <= !id_null;
      slot_number_q <= id_null ? '0 : lsm_pkg::SlotNumW'(slot_plus_one);
      was_present_q <= hit;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign accepted_o    = accepted_q;
  assign slot_number_o = slot_number_q;
  assign was_present_o = was_present_q;

  // stored identifiers stay unique, so a real identifier matches at most one cell
  // (a null all-ones identifier may match every empty cell, and is ignored)
  a_match_unique: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == StCommit) && !id_null) |-> $onehot0(match_w))
    else $error("more than one cell matched");

  // an update always leaves a result in the output register
  a_commit_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit |=> out_valid_q)
    else $error("update without result");

  // an accepted item always goes to the compare cycle
  a_accept_cmp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> (state_q == StCmp))
    else $error("accepted item skipped compare");

  // a waiting result blocks the update cycle
  a_hold_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == StCommit) && out_valid_q && out_stall_i) |=> (state_q == StCommit))
    else $error("update left while output stalled");

endmodule

`default_nettype wire

[bench/lru_id_to_slot_mapper_top_tb.sv]
`timescale 1ns / 100ps

module lru_id_to_slot_mapper_top_tb;

  // slot count the block is built with; the shadow table below follows it
  localparam int unsigned NSlots  = lsm_pkg::SlotsDef;
  localparam int unsigned IdxW    = $clog2(NSlots);
  localparam int unsigned NumDir  = 21;
  localparam int unsigned NumRand = 300;    // per idling phase, three phases
  localparam int unsigned PoolSz  = 12;     // a few more ids than slots: hits and evictions
  localparam int unsigned HoldLen = 64;     // long receiver hold-off, in cycles

  typedef logic [IdxW-1:0] slot_idx_t;

  typedef struct packed {
    logic                         accepted;
    logic [lsm_pkg::SlotNumW-1:0] slot_number;
    logic                         was_present;
  } slot_result_t;

  // directed row: identifier, whether the expected result is typed in, and that result
  typedef struct packed {
    logic [lsm_pkg::IdW-1:0]      id;
    logic                         typed;
    logic                         acc;
    logic [lsm_pkg::SlotNumW-1:0] slot;
    logic                         hit;
  } dir_row_t;

  logic                           clk_i;
  logic                           rst_ni;
  logic                           in_valid_i;
  logic                           in_stall_o;
  logic signed [lsm_pkg::IdW-1:0] identifier_i;
  logic                           out_valid_o;
  logic                           out_stall_i;
  logic                           accepted_o;
  logic [lsm_pkg::SlotNumW-1:0]   slot_number_o;
  logic                           was_present_o;

  lru_id_to_slot_mapper_top #(
    .SLOTS(NSlots)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .identifier_i (identifier_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .accepted_o   (accepted_o),
    .slot_number_o(slot_number_o),
    .was_present_o(was_present_o)
  );

  // ---------------------------------------------------------------------------
  // shadow of the tag table and its recency chain
  // ---------------------------------------------------------------------------
  logic [lsm_pkg::IdW-1:0] cache_tag  [NSlots];
  slot_idx_t               newer_link [NSlots];  // each slot points at the next newer one
  slot_idx_t               lru_slot;
  slot_idx_t               mru_slot;

  slot_result_t pending_slots [$];      // expected results, oldest first
  int unsigned  mismatch_cnt = 0;

  function automatic void clear_table();
    for (int i = 0; i < NSlots; i++) begin
      cache_tag[i]  = lsm_pkg::EmptyTag;
      newer_link[i] = slot_idx_t'((i + 1) % NSlots);
    end
    lru_slot = '0;
    mru_slot = slot_idx_t'(NSlots - 1);
  endfunction

  // map one identifier and move the used slot to the newest end of the chain
  function automatic slot_result_t lru_map(input logic [lsm_pkg::IdW-1:0] id);
    slot_result_t res;
    slot_idx_t    cur;
    slot_idx_t    prev;
    bit           hit;
    res = '0;
    // null item: rejected, nothing moves
    if (id[lsm_pkg::IdW-1]) return res;
    cur  = lru_slot;
    prev = cur;
    hit  = 1'b0;
    // walk from oldest to newest; empty slots hold all ones and never match
    for (int k = 0; k < NSlots; k++) begin
      if (cache_tag[cur] == id) begin
        hit = 1'b1;
        break;
      end
      if (cur == mru_slot) break;
      prev = cur;
      cur  = newer_link[cur];
    end
    // miss: evict the oldest, its predecessor in the ring is the newest
    if (!hit) begin
      cur  = lru_slot;
      prev = mru_slot;
    end
    cache_tag[cur] = id;
    // a hit on the newest slot leaves the chain alone
    if (cur != mru_slot) begin
      if (cur == lru_slot) lru_slot = newer_link[cur];
      newer_link[prev]     = newer_link[cur];
      newer_link[mru_slot] = cur;
      mru_slot             = cur;
      newer_link[cur]      = lru_slot;
    end
    res.accepted    = 1'b1;
    res.slot_number = lsm_pkg::SlotNumW'(int'(cur) + 1);
    res.was_present = hit;
    return res;
  endfunction

  task automatic report_mismatch(input string what);
    mismatch_cnt++;
    $display("%0t ns  mismatch: %s", $time, what);
  endtask

  // ---------------------------------------------------------------------------
  // clock, reset and the overall time limit
  // ---------------------------------------------------------------------------
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // far beyond the slowest legal run of 921 transfers
  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // receiver: random stalls, plus long hold-offs on request from the stimulus
  // ---------------------------------------------------------------------------
  int unsigned rx_idle_pct  = 58;
  int unsigned holds_asked  = 0;   // bumped by the stimulus side
  int unsigned holds_served = 0;
  int unsigned hold_left    = 0;

  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left == 0 && holds_served != holds_asked) begin
        holds_served++;
        hold_left = HoldLen;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < rx_idle_pct);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result checker: every output transfer against the oldest expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : check_results
    slot_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_slots.size() == 0) begin
        report_mismatch($sformatf("result with nothing expected (acc %0b slot %0d hit %0b)",
                                  accepted_o, slot_number_o, was_present_o));
      end else begin
        want = pending_slots.pop_front();
        if (accepted_o !== want.accepted)
          report_mismatch($sformatf("accepted %0b, expected %0b", accepted_o, want.accepted));
        if (slot_number_o !== want.slot_number)
          report_mismatch($sformatf("slot_number %0d, expected %0d",
                                    slot_number_o, want.slot_number));
        if (was_present_o !== want.was_present)
          report_mismatch($sformatf("was_present %0b, expected %0b",
                                    was_present_o, want.was_present));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // sender
  // ---------------------------------------------------------------------------
  int unsigned tx_idle_pct = 31;

  // offer one identifier; called and returning at a falling edge, so valid
  // only gets one assignment per step and stays up between back-to-back items
  task automatic offer_id(input logic [lsm_pkg::IdW-1:0] id, input bit use_typed,
                          input slot_result_t typed_res);
    slot_result_t pred;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    identifier_i <= id;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    // transfer taken at this edge: advance the shadow table
    pred = lru_map(id);
    pending_slots.push_back(use_typed ? typed_res : pred);
    @(negedge clk_i);
  endtask

  // directed rows; typed expectations only where they are obvious
  dir_row_t dir_tab [NumDir] = '{
    '{32'h0000_0000, 1'b1, 1'b1, 4'd1, 1'b0},  // first id after reset takes slot 0, reported as slot number 1
    '{32'hFFFF_FFFF, 1'b1, 1'b0, 4'd0, 1'b0},  // null that equals the empty pattern
    '{32'h8000_0000, 1'b1, 1'b0, 4'd0, 1'b0},  // most negative id, null
    '{32'h7FFF_FFFF, 1'b1, 1'b1, 4'd2, 1'b0},  // largest id, next oldest slot
    '{32'h0000_0000, 1'b1, 1'b1, 4'd1, 1'b1},  // hit, not the newest
    '{32'h0000_0000, 1'b1, 1'b1, 4'd1, 1'b1},  // hit on the newest slot
    '{32'h0000_0001, 1'b0, 1'b0, 4'd0, 1'b0},  // fill the rest of the table
    '{32'h0000_0002, 1'b0, 1'b0, 4'd0, 1'b0},
    '{32'h0000_0003, 1'b0, 1'b0, 4'd0, 1'b0},
    '{32'h0000_0004, 1'b0, 1'b0, 4'd0, 1'b0},
    '{32'h0000_0005, 1'b0, 1'b0, 4'd0, 1'b0},
    '{32'h0000_0006, 1'b0, 1'b0, 4'd0, 1'b0},
    '{32'h0000_0064, 1'b0, 1'b0, 4'd0, 1'b0},  // full table: evicts the oldest
    '{32'h7FFF_FFFF, 1'b0, 1'b0, 4'd0, 1'b0},  // evicted id comes back as a miss
    '{32'h5555_5555, 1'b0, 1'b0, 4'd0, 1'b0},
    '{32'h2AAA_AAAA, 1'b0, 1'b0, 4'd0, 1'b0},
    '{32'h0000_0003, 1'b0, 1'b0, 4'd0, 1'b0},  // hit on the oldest slot of the chain
    '{32'hFFFF_FFFE, 1'b1, 1'b0, 4'd0, 1'b0},  // null between hits
    '{32'h0000_0005, 1'b0, 1'b0, 4'd0, 1'b0},
    '{32'h0000_0006, 1'b0, 1'b0, 4'd0, 1'b0},
    '{32'h0000_0000, 1'b0, 1'b0, 4'd0, 1'b0}
  };

  logic [lsm_pkg::IdW-1:0] id_pool [PoolSz];

  // mostly ids from a small pool so the table keeps hitting and evicting,
  // the rest fresh ids and nulls with random low bits
  function automatic logic [lsm_pkg::IdW-1:0] pick_id();
    logic [lsm_pkg::IdW-1:0] raw;
    int unsigned             sel;
    int unsigned             which;
    raw = $urandom;
    sel = $urandom_range(99);
    if (sel < 12) return {1'b1, raw[lsm_pkg::IdW-2:0]};
    if (sel < 25) return {1'b0, raw[lsm_pkg::IdW-2:0]};
    which = $urandom_range(PoolSz - 1);
    // slowly swap pool entries so old ids age out of the table
    if ($urandom_range(19) == 0) id_pool[which] = {1'b0, raw[lsm_pkg::IdW-2:0]};
    return id_pool[which];
  endfunction

  initial begin : stimulus
    slot_result_t typed_res;
    int unsigned  wait_cyc;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    identifier_i = '0;
    clear_table();
    for (int i = 0; i < PoolSz; i++) id_pool[i] = {1'b0, 31'($urandom)};
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed part, under the first idling mix
    foreach (dir_tab[i]) begin
      typed_res = '{dir_tab[i].acc, dir_tab[i].slot, dir_tab[i].hit};
      offer_id(dir_tab[i].id, dir_tab[i].typed, typed_res);
    end

    // phase 1: sender idles 31%, receiver 58%, one long hold-off midway
    for (int n = 0; n < NumRand; n++) begin
      if (n == NumRand / 2) holds_asked <= holds_asked + 1;
      offer_id(pick_id(), 1'b0, '0);
    end

    // phase 2: roles swapped
    tx_idle_pct = 58;
    rx_idle_pct <= 31;
    for (int n = 0; n < NumRand; n++) offer_id(pick_id(), 1'b0, '0);

    // phase 3: no idling; a hold-off right away backs the block up
    // into its input while the sender keeps offering
    tx_idle_pct = 0;
    rx_idle_pct <= 0;
    holds_asked <= holds_asked + 1;
    for (int n = 0; n < NumRand; n++) offer_id(pick_id(), 1'b0, '0);
    in_valid_i <= 1'b0;

    // drain, then keep watching for anything stray
    wait_cyc = 0;
    while (pending_slots.size() != 0 && wait_cyc < 5000) begin
      @(posedge clk_i);
      wait_cyc++;
    end
    repeat (10) @(posedge clk_i);
    if (pending_slots.size() != 0)
      report_mismatch($sformatf("%0d expected results never arrived", pending_slots.size()));

    if (mismatch_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
